@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared clocking and reporting for the checker assertions
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion that is quiet while reset is high
`define ETM_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("etm assertion failed");

// assertion that also watches the reset cycles
`define ETM_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("etm reset assertion failed");

`endif

@@ src/etm_pkg.sv @@
// ----------------------------------------------------------------------------
// etm_pkg
// types, constants and the arctangent table of the transform matrix block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package etm_pkg;

   // field widths
   localparam int ANGLE_WIDTH  = 16;
   localparam int SCALE_WIDTH  = 16;
   localparam int MOVE_WIDTH   = 32;
   localparam int OUT_WIDTH    = 32;
   localparam int PHASE_WIDTH  = 32;

   // cordic
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES      = 30;
   localparam int CORDIC_WIDTH      = 34;
   localparam int ATAN_IDX_WIDTH    = 5;

   localparam logic [33:0] PHASE_MUL = 34'd10937044409;
   localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic signed [CORDIC_WIDTH-1:0] QUARTER_TURN    = 34'sd1073741824;
   localparam logic signed [CORDIC_WIDTH-1:0] HALF_TURN       = 34'sd2147483648;

   // matrix_kind codes
   localparam logic MATRIX_MODEL  = 1'b0;
   localparam logic MATRIX_NORMAL = 1'b1;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] rot_x_rad;
      logic signed [ANGLE_WIDTH-1:0] rot_y_rad;
      logic signed [ANGLE_WIDTH-1:0] rot_z_rad;
      logic signed [SCALE_WIDTH-1:0] scale_x;
      logic signed [SCALE_WIDTH-1:0] scale_y;
      logic signed [SCALE_WIDTH-1:0] scale_z;
      logic signed [MOVE_WIDTH-1:0]  move_x;
      logic signed [MOVE_WIDTH-1:0]  move_y;
      logic signed [MOVE_WIDTH-1:0]  move_z;
   } req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] col0_x;
      logic signed [OUT_WIDTH-1:0] col0_y;
      logic signed [OUT_WIDTH-1:0] col0_z;
      logic signed [OUT_WIDTH-1:0] col1_x;
      logic signed [OUT_WIDTH-1:0] col1_y;
      logic signed [OUT_WIDTH-1:0] col1_z;
      logic signed [OUT_WIDTH-1:0] col2_x;
      logic signed [OUT_WIDTH-1:0] col2_y;
      logic signed [OUT_WIDTH-1:0] col2_z;
      logic signed [OUT_WIDTH-1:0] col3_x;
      logic signed [OUT_WIDTH-1:0] col3_y;
      logic signed [OUT_WIDTH-1:0] col3_z;
   } rsp_type;

   // arctangent of 2^-idx in phase units (full turn = 2^32)
   function automatic logic signed [CORDIC_WIDTH-1:0] atan_entry(
      input logic [ATAN_IDX_WIDTH-1:0] idx);
      logic signed [CORDIC_WIDTH-1:0] val;
      unique case (idx)
         5'd0:    val = 34'sh20000000;
         5'd1:    val = 34'sh12E4051D;
         5'd2:    val = 34'sh09FB385B;
         5'd3:    val = 34'sh051111D4;
         5'd4:    val = 34'sh028B0D43;
         5'd5:    val = 34'sh0145D7E1;
         5'd6:    val = 34'sh00A2F61E;
         5'd7:    val = 34'sh00517C55;
         5'd8:    val = 34'sh0028BE53;
         5'd9:    val = 34'sh00145F2E;
         5'd10:   val = 34'sh000A2F98;
         5'd11:   val = 34'sh000517CC;
         5'd12:   val = 34'sh00028BE6;
         5'd13:   val = 34'sh000145F3;
         5'd14:   val = 34'sh0000A2F9;
         5'd15:   val = 34'sh0000517C;
         5'd16:   val = 34'sh000028BE;
         5'd17:   val = 34'sh0000145F;
         5'd18:   val = 34'sh00000A2F;
         5'd19:   val = 34'sh00000517;
         5'd20:   val = 34'sh0000028B;
         5'd21:   val = 34'sh00000145;
         5'd22:   val = 34'sh000000A2;
         5'd23:   val = 34'sh00000051;
         5'd24:   val = 34'sh00000028;
         5'd25:   val = 34'sh00000014;
         5'd26:   val = 34'sh0000000A;
         5'd27:   val = 34'sh00000005;
         5'd28:   val = 34'sh00000002;
         5'd29:   val = 34'sh00000001;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ src/euler_trs_transform_matrix.sv @@
// ----------------------------------------------------------------------------
// euler_trs_transform_matrix
// pose to 4x4 model matrix (y, x, z rotation, scale, translation) or to the
// inverse-scaled normal matrix, selected by the matrix_kind register
// ----------------------------------------------------------------------------
// One pose is taken every cycle while req_stall is low, and its twelve matrix
// entries come out after the cordic, product, scaling and divider stages. The
// latency is set by the fully unrolled CORDIC (one stage per iteration) and by
// the normal-mode divider, which resolves one quotient bit per stage over a
// 37-bit dividend; both run on every pose so the latency does not depend on the
// mode. The whole pipeline moves as one: a stalled result holds every stage and
// req_stall follows at once. matrix_kind is written through the csr port (always
// ready) and must only change while no pose is in flight.
`timescale 1ns / 1ps
`default_nettype none

module euler_trs_transform_matrix
   import etm_pkg::*;
#(
   parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic    csr_data
);

   // widths
   localparam int CW   = CORDIC_WIDTH;
   localparam int PRW  = ANGLE_WIDTH + 35;
   localparam int RW   = CW + 2;
   localparam int MW   = RW + SCALE_WIDTH;
   localparam int DW   = SCALE_WIDTH;
   localparam int NW   = RW + 1;
   localparam int SW   = NW + 2;
   localparam int NSTG = CORDIC_STAGES;

   // stage positions
   localparam int S_MUL  = 6 + NSTG;
   localparam int LAST   = 8 + NSTG + NW;
   localparam int NSTAGE = LAST + 1;

   localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(OUT_WIDTH-1){1'b1}}});
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
   localparam logic [MW:0] MODEL_HALF = (MW+1)'(1) << 21;

   typedef struct packed {
      logic [2:0][SCALE_WIDTH-1:0] scale;
      logic [2:0][MOVE_WIDTH-1:0]  move;
      logic                        kind;
   } side_type;

   typedef struct packed {
      logic [8:0][OUT_WIDTH-1:0] model;
      logic [2:0][OUT_WIDTH-1:0] col3;
      logic                      kind;
   } tail_type;

   // q2.30 product with floor shift
   function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] pr;
      pr = a * b;
      return pr[CW+29:30];
   endfunction

   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] c;
      c = v;
      if (v > SAT_HI) c = SAT_HI;
      if (v < SAT_LO) c = SAT_LO;
      return OUT_WIDTH'(c);
   endfunction

   logic                   adv;
   logic [NSTAGE-1:0]      vld_ff;
   logic                   kind_ff;
   side_type               side_ff [S_MUL+1];

   logic signed [ANGLE_WIDTH-1:0] ang_ff [3];
   logic [PHASE_WIDTH-1:0]        ph_ff  [3];
   logic signed [PRW-1:0]         ph_prod [3];

   logic signed [CW-1:0] cx_ff [NSTG+1][3];
   logic signed [CW-1:0] cy_ff [NSTG+1][3];
   logic signed [CW-1:0] cz_ff [NSTG+1][3];
   logic                 cf_ff [NSTG+1][3];
   logic signed [CW-1:0] cx_in [NSTG][3];
   logic signed [CW-1:0] cy_in [NSTG][3];
   logic signed [CW-1:0] cz_in [NSTG][3];
   logic signed [CW-1:0] fz_in [3];
   logic                 ff_in [3];

   logic signed [CW-1:0] sn_ff [3];
   logic signed [CW-1:0] cs_ff [3];

   logic signed [CW-1:0] p_c1c3_ff, p_s1s2_ff, p_c2s3_ff, p_c1s2_ff, p_c3s1_ff;
   logic signed [CW-1:0] p_c2c3_ff, p_c2s1_ff, p_c1c2_ff, p_s1s3_ff, p_c1s3_ff;
   logic signed [CW-1:0] p_s2_ff, p_s3_ff;

   logic signed [RW-1:0] r_ff [9];
   logic signed [RW-1:0] r_in [9];

   logic signed [MW-1:0] m_ff    [9];
   logic [RW-1:0]        rab_ff  [9];
   logic                 rpos_ff [9];
   logic                 rneg_ff [9];

   logic [DW-1:0]        dv_rem_ff  [NW+1][9];
   logic [NW-1:0]        dv_num_ff  [NW+1][9];
   logic [DW-1:0]        dv_d_ff    [NW+1][9];
   logic                 dv_neg_ff  [NW+1][9];
   logic                 dv_zero_ff [NW+1][9];
   logic                 dv_pos_ff  [NW+1][9];
   logic                 dv_rng_ff  [NW+1][9];
   tail_type             tail_ff    [NW+1];

   logic [DW-1:0]        dv_rem_in [NW][9];
   logic [NW-1:0]        dv_num_in [NW][9];
   logic [DW-1:0]        d0_in     [9];
   logic [NW-1:0]        n0_in     [9];
   logic                 neg0_in   [9];
   logic                 zero0_in  [9];
   tail_type             tail0_in;

   rsp_type              rsp_ff;
   logic [OUT_WIDTH-1:0] ent_in [12];

   // whole pipeline advances when the output slot is free or taken
   assign adv       = !vld_ff[LAST] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         kind_ff <= MATRIX_MODEL;
      end else begin
         if (adv) vld_ff <= {vld_ff[NSTAGE-2:0], req_valid};
         if (csr_valid && csr_ready) kind_ff <= csr_data;
      end
   end

   // phase multiply and quadrant fold
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ph_prod[k] = PRW'(ang_ff[k]) * $signed({1'b0, PHASE_MUL});
         fz_in[k]   = CW'($signed(ph_ff[k]));
         ff_in[k]   = 1'b0;
         if (fz_in[k] > QUARTER_TURN) begin
            fz_in[k] = fz_in[k] - HALF_TURN;
            ff_in[k] = 1'b1;
         end else if (fz_in[k] < -QUARTER_TURN) begin
            fz_in[k] = fz_in[k] + HALF_TURN;
            ff_in[k] = 1'b1;
         end
      end
   end

   // cordic iterations, one per stage
   always_comb begin
      for (int i = 0; i < NSTG; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (cz_ff[i][k] >= 0) begin
               cx_in[i][k] = cx_ff[i][k] - (cy_ff[i][k] >>> i);
               cy_in[i][k] = cy_ff[i][k] + (cx_ff[i][k] >>> i);
               cz_in[i][k] = cz_ff[i][k] - atan_entry(ATAN_IDX_WIDTH'(i));
            end else begin
               cx_in[i][k] = cx_ff[i][k] + (cy_ff[i][k] >>> i);
               cy_in[i][k] = cy_ff[i][k] - (cx_ff[i][k] >>> i);
               cz_in[i][k] = cz_ff[i][k] + atan_entry(ATAN_IDX_WIDTH'(i));
            end
         end
      end
   end

   // rotation entries: index 1 is angle y (s1, c1), 0 is x (s2, c2), 2 is z
   always_comb begin
      r_in[0] = RW'(p_c1c3_ff) + RW'(mul30(p_s1s2_ff, p_s3_ff));
      r_in[1] = RW'(p_c2s3_ff);
      r_in[2] = RW'(mul30(p_c1s2_ff, p_s3_ff)) - RW'(p_c3s1_ff);
      r_in[3] = RW'(mul30(p_c3s1_ff, p_s2_ff)) - RW'(p_c1s3_ff);
      r_in[4] = RW'(p_c2c3_ff);
      r_in[5] = RW'(mul30(p_c1c3_ff, p_s2_ff)) + RW'(p_s1s3_ff);
      r_in[6] = RW'(p_c2s1_ff);
      r_in[7] = -RW'(p_s2_ff);
      r_in[8] = RW'(p_c1c2_ff);
   end

   // model rounding and divider setup
   always_comb begin
      logic signed [SCALE_WIDTH-1:0] sv;
      logic [MW-1:0]                 mag;
      logic [MW:0]                   q;
      logic signed [SW-1:0]          mv;
      tail0_in      = '0;
      tail0_in.kind = side_ff[S_MUL].kind;
      for (int k = 0; k < 9; k++) begin
         sv          = $signed(side_ff[S_MUL].scale[k/3]);
         d0_in[k]    = (sv < 0) ? DW'(-sv) : DW'(sv);
         zero0_in[k] = (sv == 0);
         neg0_in[k]  = rneg_ff[k] ^ (sv < 0);
         n0_in[k]    = NW'(rab_ff[k]) + (NW'(d0_in[k]) << 5);
         mag         = (m_ff[k] < 0) ? MW'(-m_ff[k]) : MW'(m_ff[k]);
         q           = ((MW+1)'(mag) + MODEL_HALF) >> 22;
         mv          = (m_ff[k] < 0) ? -SW'(q) : SW'(q);
         tail0_in.model[k] = sat_out(mv);
      end
      for (int k = 0; k < 3; k++) begin
         tail0_in.col3[k] = (side_ff[S_MUL].kind == MATRIX_NORMAL) ? '0 :
                            sat_out(SW'($signed(side_ff[S_MUL].move[k])));
      end
   end

   // restoring divider, one quotient bit per stage
   always_comb begin
      logic [DW:0] t;
      for (int j = 0; j < NW; j++) begin
         for (int k = 0; k < 9; k++) begin
            t = {dv_rem_ff[j][k], dv_num_ff[j][k][NW-1]};
            if (t >= {1'b0, dv_d_ff[j][k]}) begin
               dv_rem_in[j][k] = DW'(t - {1'b0, dv_d_ff[j][k]});
               dv_num_in[j][k] = {dv_num_ff[j][k][NW-2:0], 1'b1};
            end else begin
               dv_rem_in[j][k] = t[DW-1:0];
               dv_num_in[j][k] = {dv_num_ff[j][k][NW-2:0], 1'b0};
            end
         end
      end
   end

   // final select between model and normal entries
   always_comb begin
      logic signed [SW-1:0] nv;
      for (int k = 0; k < 9; k++) begin
         nv = SW'(dv_num_ff[NW][k][NW-1:6]);
         if (dv_neg_ff[NW][k]) nv = -nv;
         if (tail_ff[NW].kind == MATRIX_MODEL) begin
            ent_in[k] = tail_ff[NW].model[k];
         end else if (dv_zero_ff[NW][k]) begin
            if (dv_pos_ff[NW][k])      ent_in[k] = OUT_WIDTH'(SAT_HI);
            else if (dv_rng_ff[NW][k]) ent_in[k] = OUT_WIDTH'(SAT_LO);
            else                       ent_in[k] = '0;
         end else begin
            ent_in[k] = sat_out(nv);
         end
      end
      for (int k = 0; k < 3; k++) ent_in[9 + k] = tail_ff[NW].col3[k];
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         // input beat
         ang_ff[0]          <= req_data.rot_x_rad;
         ang_ff[1]          <= req_data.rot_y_rad;
         ang_ff[2]          <= req_data.rot_z_rad;
         side_ff[0].scale   <= {req_data.scale_z, req_data.scale_y, req_data.scale_x};
         side_ff[0].move    <= {req_data.move_z, req_data.move_y, req_data.move_x};
         side_ff[0].kind    <= kind_ff;
         for (int j = 1; j <= S_MUL; j++) side_ff[j] <= side_ff[j-1];

         for (int k = 0; k < 3; k++) begin
            ph_ff[k]    <= ph_prod[k][47:16];
            cx_ff[0][k] <= CORDIC_GAIN_INV;
            cy_ff[0][k] <= '0;
            cz_ff[0][k] <= fz_in[k];
            cf_ff[0][k] <= ff_in[k];
            for (int i = 0; i < NSTG; i++) begin
               cx_ff[i+1][k] <= cx_in[i][k];
               cy_ff[i+1][k] <= cy_in[i][k];
               cz_ff[i+1][k] <= cz_in[i][k];
               cf_ff[i+1][k] <= cf_ff[i][k];
            end
            sn_ff[k] <= cf_ff[NSTG][k] ? -cy_ff[NSTG][k] : cy_ff[NSTG][k];
            cs_ff[k] <= cf_ff[NSTG][k] ? -cx_ff[NSTG][k] : cx_ff[NSTG][k];
         end

         // pairwise products
         p_c1c3_ff <= mul30(cs_ff[1], cs_ff[2]);
         p_s1s2_ff <= mul30(sn_ff[1], sn_ff[0]);
         p_c2s3_ff <= mul30(cs_ff[0], sn_ff[2]);
         p_c1s2_ff <= mul30(cs_ff[1], sn_ff[0]);
         p_c3s1_ff <= mul30(cs_ff[2], sn_ff[1]);
         p_c2c3_ff <= mul30(cs_ff[0], cs_ff[2]);
         p_c2s1_ff <= mul30(cs_ff[0], sn_ff[1]);
         p_c1c2_ff <= mul30(cs_ff[1], cs_ff[0]);
         p_s1s3_ff <= mul30(sn_ff[1], sn_ff[2]);
         p_c1s3_ff <= mul30(cs_ff[1], sn_ff[2]);
         p_s2_ff   <= sn_ff[0];
         p_s3_ff   <= sn_ff[2];

         for (int k = 0; k < 9; k++) begin
            r_ff[k]    <= r_in[k];
            m_ff[k]    <= MW'(r_ff[k]) * MW'($signed(side_ff[S_MUL-1].scale[k/3]));
            rab_ff[k]  <= (r_ff[k] < 0) ? RW'(-r_ff[k]) : RW'(r_ff[k]);
            rpos_ff[k] <= (r_ff[k] > 0);
            rneg_ff[k] <= (r_ff[k] < 0);

            dv_rem_ff[0][k]  <= '0;
            dv_num_ff[0][k]  <= n0_in[k];
            dv_d_ff[0][k]    <= d0_in[k];
            dv_neg_ff[0][k]  <= neg0_in[k];
            dv_zero_ff[0][k] <= zero0_in[k];
            dv_pos_ff[0][k]  <= rpos_ff[k];
            dv_rng_ff[0][k]  <= rneg_ff[k];
            for (int j = 0; j < NW; j++) begin
               dv_rem_ff[j+1][k]  <= dv_rem_in[j][k];
               dv_num_ff[j+1][k]  <= dv_num_in[j][k];
               dv_d_ff[j+1][k]    <= dv_d_ff[j][k];
               dv_neg_ff[j+1][k]  <= dv_neg_ff[j][k];
               dv_zero_ff[j+1][k] <= dv_zero_ff[j][k];
               dv_pos_ff[j+1][k]  <= dv_pos_ff[j][k];
               dv_rng_ff[j+1][k]  <= dv_rng_ff[j][k];
            end
         end
         tail_ff[0] <= tail0_in;
         for (int j = 0; j < NW; j++) tail_ff[j+1] <= tail_ff[j];

         // output beat
         rsp_ff.col0_x <= ent_in[0];
         rsp_ff.col0_y <= ent_in[1];
         rsp_ff.col0_z <= ent_in[2];
         rsp_ff.col1_x <= ent_in[3];
         rsp_ff.col1_y <= ent_in[4];
         rsp_ff.col1_z <= ent_in[5];
         rsp_ff.col2_x <= ent_in[6];
         rsp_ff.col2_y <= ent_in[7];
         rsp_ff.col2_z <= ent_in[8];
         rsp_ff.col3_x <= ent_in[9];
         rsp_ff.col3_y <= ent_in[10];
         rsp_ff.col3_z <= ent_in[11];
      end
   end

endmodule

`default_nettype wire

@@ src/etm_checker.sv @@
// ----------------------------------------------------------------------------
// etm_checker
// port-level checks of the transform matrix block, bound into each of its instances
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module etm_checker
   import etm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data,
   input wire logic    csr_valid,
   input wire logic    csr_ready,
   input wire logic    csr_data
);

   logic chk_kind_ff;
   logic col3_zero;

   // mirror of the mode register as seen on the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_kind_ff <= MATRIX_MODEL;
      end else if (csr_valid && csr_ready) begin
         chk_kind_ff <= csr_data;
      end
   end

   // translation column of the current result beat is all zero
   assign col3_zero = (rsp_data.col3_x == 0) && (rsp_data.col3_y == 0) &&
                      (rsp_data.col3_z == 0);

   // no result beat right after reset
   `ETM_ASSERT_RST(a_reset_empty, reset |=> !rsp_valid)
   // a held result back-pressures the input side in the same cycle
   `ETM_ASSERT(a_stall_chain, (rsp_valid && rsp_stall) |-> req_stall)
   // normal matrix carries no translation
   `ETM_ASSERT(a_normal_col3, (rsp_valid && chk_kind_ff == MATRIX_NORMAL) |-> col3_zero)
   // stalled result stays
   `ETM_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> rsp_valid)
   `ETM_ASSERT(a_rsp_stable, (rsp_valid && rsp_stall) |=> $stable(rsp_data))

endmodule

bind euler_trs_transform_matrix etm_checker u_etm_checker (.*);

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream test of the euler transform matrix block: poses go in with random
// gaps, matrices come out under random stalls and are compared field by
// field with a bit-exact predictor of cordic, products, scaling and rounding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import etm_pkg::*;

   localparam int LATENCY   = 61;
   localparam int WD_LIMIT  = 4000;
   localparam int N_RANDOM  = 600;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   logic    kind_now = MATRIX_MODEL;
   rsp_type matrix_queue[$];
   int      n_fail = 0;
   int      n_poses = 0;
   int      n_checked = 0;
   int      idle_cycles = 0;
   bit      hold_off = 1'b0;
   int      hold_len = 0;
   int      sender_gap_max = 18;
   int      recv_gap_max = 18;

   euler_trs_transform_matrix DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint q30_mul(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic longint clamp_out(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (OUT_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic longint round_div(longint num, longint den);
      longint n, d, q;
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = (n + d / 2) / d;
      return ((num < 0) != (den < 0)) ? -q : q;
   endfunction

   function automatic longint atan_phase(int i);
      longint t[30] = '{
         'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
         'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
         'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
         'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051,
         'h00000028, 'h00000014, 'h0000000A, 'h00000005, 'h00000002, 'h00000001};
      return t[i];
   endfunction

   // sine and cosine in q2.30 of a q4.12 angle
   task automatic angle_sincos(input logic signed [ANGLE_WIDTH-1:0] ang,
                               output longint sn, output longint cs);
      longint a, z, x, y, dx, dy;
      logic [63:0] prod;
      logic [31:0] ph;
      bit flip;
      a = ang;
      prod = a * 64'd10937044409;
      ph = prod[47:16];
      z = ph[31] ? longint'(ph) - 64'sd4294967296 : longint'(ph);
      flip = 1'b0;
      x = 652032874;
      y = 0;
      if (z > 64'sd1073741824) begin
         z -= 64'sd2147483648;
         flip = 1'b1;
      end else if (z < -64'sd1073741824) begin
         z += 64'sd2147483648;
         flip = 1'b1;
      end
      for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_phase(i);
         end else begin
            x += dx; y -= dy; z += atan_phase(i);
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endtask

   function automatic logic [OUT_WIDTH-1:0] matrix_entry(longint r, longint s, logic kind);
      longint lim;
      lim = (64'sd1 <<< (OUT_WIDTH - 1)) - 1;
      if (kind == MATRIX_MODEL) return OUT_WIDTH'(clamp_out(round_div(r * s, 4194304)));
      if (s == 0) begin
         if (r > 0) return OUT_WIDTH'(lim);
         if (r < 0) return OUT_WIDTH'(-lim - 1);
         return '0;
      end
      return OUT_WIDTH'(clamp_out(round_div(r, s * 64)));
   endfunction

   task automatic predict_matrix(input req_type p, input logic kind, output rsp_type m);
      longint s1, c1, s2, c2, s3, c3, sx, sy, sz;
      longint r[9];
      angle_sincos(p.rot_y_rad, s1, c1);
      angle_sincos(p.rot_x_rad, s2, c2);
      angle_sincos(p.rot_z_rad, s3, c3);
      sx = p.scale_x; sy = p.scale_y; sz = p.scale_z;
      r[0] = q30_mul(c1, c3) + q30_mul(q30_mul(s1, s2), s3);
      r[1] = q30_mul(c2, s3);
      r[2] = q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1);
      r[3] = q30_mul(q30_mul(c3, s1), s2) - q30_mul(c1, s3);
      r[4] = q30_mul(c2, c3);
      r[5] = q30_mul(q30_mul(c1, c3), s2) + q30_mul(s1, s3);
      r[6] = q30_mul(c2, s1);
      r[7] = -s2;
      r[8] = q30_mul(c1, c2);
      m.col0_x = matrix_entry(r[0], sx, kind);
      m.col0_y = matrix_entry(r[1], sx, kind);
      m.col0_z = matrix_entry(r[2], sx, kind);
      m.col1_x = matrix_entry(r[3], sy, kind);
      m.col1_y = matrix_entry(r[4], sy, kind);
      m.col1_z = matrix_entry(r[5], sy, kind);
      m.col2_x = matrix_entry(r[6], sz, kind);
      m.col2_y = matrix_entry(r[7], sz, kind);
      m.col2_z = matrix_entry(r[8], sz, kind);
      m.col3_x = (kind == MATRIX_NORMAL) ? '0 : p.move_x;
      m.col3_y = (kind == MATRIX_NORMAL) ? '0 : p.move_y;
      m.col3_z = (kind == MATRIX_NORMAL) ? '0 : p.move_z;
   endtask

   // ---------------- drivers ----------------
   task automatic wait_cycles(int n);
      repeat (n) @(posedge clock);
   endtask

   // send one pose beat and queue its expected matrix
   task automatic send_pose(input req_type p);
      rsp_type m;
      int      gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         wait_cycles(gap);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_matrix(p, kind_now, m);
      matrix_queue.push_back(m);
      n_poses++;
   endtask

   task automatic drain_pipe;
      req_valid <= 1'b0;
      while (matrix_queue.size() != 0) @(posedge clock);
      wait_cycles(LATENCY + 4);
   endtask

   task automatic write_kind(input logic kind);
      csr_valid <= 1'b1;
      csr_data  <= kind;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      kind_now = kind;
   endtask

   function automatic req_type random_pose();
      req_type p;
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      // mostly moderate scales, sometimes zero or full range
      case ($urandom_range(0, 5))
         0: ;
         1: p.scale_x = 16'sd0;
         default: begin
            p.scale_x = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            p.scale_y = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
            p.scale_z = $signed(16'($urandom_range(0, 1023))) - 16'sd512;
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         p.rot_x_rad = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
         p.rot_y_rad = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
         p.rot_z_rad = $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
      end
      return p;
   endfunction

   // ---------------- result checker ----------------
   task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         n_fail++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type m;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (matrix_queue.size() == 0) begin
            $error("unexpected matrix beat %h", rsp_data);
            n_fail++;
         end else begin
            m = matrix_queue.pop_front();
            cmp_field("col0_x", m.col0_x, rsp_data.col0_x);
            cmp_field("col0_y", m.col0_y, rsp_data.col0_y);
            cmp_field("col0_z", m.col0_z, rsp_data.col0_z);
            cmp_field("col1_x", m.col1_x, rsp_data.col1_x);
            cmp_field("col1_y", m.col1_y, rsp_data.col1_y);
            cmp_field("col1_z", m.col1_z, rsp_data.col1_z);
            cmp_field("col2_x", m.col2_x, rsp_data.col2_x);
            cmp_field("col2_y", m.col2_y, rsp_data.col2_y);
            cmp_field("col2_z", m.col2_z, rsp_data.col2_z);
            cmp_field("col3_x", m.col3_x, rsp_data.col3_x);
            cmp_field("col3_y", m.col3_y, rsp_data.col3_y);
            cmp_field("col3_z", m.col3_z, rsp_data.col3_z);
            n_checked++;
         end
      end
   end

   // receiver stall: random per beat, or one long hold-off on request
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(posedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            gap = $urandom_range(0, recv_gap_max);
            if (gap != 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // watchdog on cycles with no beat accepted
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("euler_trs_transform_matrix verification failed");
         $finish;
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed(input logic kind);
      req_type p;
      logic signed [15:0] angs[7] = '{16'sh0000, 16'sh7FFF, -16'sh8000, 16'sd6434,
                                      -16'sd6434, 16'sd12868, 16'sd1};
      logic signed [15:0] scl[5] = '{16'sh0100, 16'sh0000, 16'sh7FFF, -16'sh8000,
                                     -16'sh0100};
      if (kind != kind_now) write_kind(kind);
      for (int i = 0; i < 10; i++) begin
         p = '0;
         p.rot_x_rad = angs[i % 7];
         p.rot_y_rad = angs[(i + 2) % 7];
         p.rot_z_rad = angs[(i + 4) % 7];
         p.scale_x = scl[i % 5];
         p.scale_y = scl[(i + 1) % 5];
         p.scale_z = scl[(i + 3) % 5];
         p.move_x = (i % 2) ? 32'sh7FFFFFFF : -32'sh80000000;
         p.move_y = 32'sh0001_8000;
         p.move_z = -32'sd1;
         send_pose(p);
      end
      drain_pipe();
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         // stretches with no idling
         sender_gap_max = ((i / 60) % 3 == 2) ? 0 : 18;
         recv_gap_max   = ((i / 60) % 3 == 2) ? 0 : 18;
         send_pose(random_pose());
      end
      drain_pipe();
   endtask

   task automatic test_backpressure;
      hold_len = 200;
      hold_off = 1'b1;
      sender_gap_max = 0;
      for (int i = 0; i < 80; i++) send_pose(random_pose());
      sender_gap_max = 18;
      drain_pipe();
   endtask

   initial begin
      wait_cycles(6);
      reset <= 1'b0;
      wait_cycles(2);
      test_directed(MATRIX_MODEL);
      write_kind(MATRIX_NORMAL);
      test_directed(MATRIX_NORMAL);
      test_random(N_RANDOM / 4);
      write_kind(MATRIX_MODEL);
      test_backpressure();
      test_random(N_RANDOM / 2);
      write_kind(MATRIX_NORMAL);
      test_random(N_RANDOM / 4);
      $display("poses sent %0d, matrices checked %0d, both matrix kinds, long stall",
               n_poses, n_checked);
      if (n_fail == 0)
         $display("euler_trs_transform_matrix verification clean");
      else
         $display("euler_trs_transform_matrix verification failed");
      $finish;
   end

endmodule
